@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b in the same cycle
`define ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// assert that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

@@ rtl/edfs_pkg.sv @@
// package for the edf scheduler: types and codes
`timescale 1ns / 1ps
package edfs_pkg;
   localparam logic [2:0] KIND_ACCEPTED = 3'd0;
   localparam logic [2:0] KIND_FULL     = 3'd1;
   localparam logic [2:0] KIND_INVALID  = 3'd2;
   localparam logic [2:0] KIND_REJECTED = 3'd3;
   localparam logic [2:0] KIND_ASSIGNED = 3'd4;
   localparam logic [2:0] KIND_MISSED   = 3'd5;
   localparam logic [2:0] KIND_IDLE     = 3'd6;
   localparam logic [2:0] KIND_STOPPED  = 3'd7;

   localparam logic [1:0] ST_EMPTY   = 2'd0;
   localparam logic [1:0] ST_PENDING = 2'd1;
   localparam logic [1:0] ST_READY   = 2'd2;

   localparam logic REG_CORE_COUNT = 1'b0;
   localparam int   MAX_RESULTS    = 8;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUB_SCAN,
      S_SUB_WAIT,
      S_REL_SCAN,
      S_CORE,
      S_BEST_SCAN,
      S_BEST_WAIT,
      S_ASSIGN,
      S_DONE_SCAN,
      S_EMIT,
      S_OUT
   } state_type;

   // one request to the slot scan unit
   typedef struct packed {
      logic start;
      logic mode_best;
   } scan_ctl_type;
endpackage

@@ rtl/edf_multicore_task_scheduler.sv @@
// top level of the edf multicore scheduler: sequencer, cores, csr and channels
//
// usage: a beat on req_ carries one command. cmd 0 submits a task into a free
// slot and gives one rsp_ beat (accepted, store full, invalid or rejected).
// cmd 1 advances time by one tick: pending tasks whose release has come
// become ready, then up to eight ready tasks with the least deadline go to
// the lowest-numbered free cores, one rsp_ beat each, or one idle or stopped
// beat. rsp_last marks the final beat of a command; rsp_all_done tells whether
// any task remains stored once the command is done.
// each pass over the slot store reads one slot a cycle through one scan unit.
// a submit gives its beat after a free-slot scan and a final scan of the store.
// a tick first collects its beats in a small result buffer, with one scan for
// the release, then one best scan per free core walked, and then sends them
// one at a time once a final scan of the store is done.
// req_ready is high only when idle; one command is handled at a time.
// reset clears all slots, core busy times, the tick and the stop flag and
// sets core_count to one. a stalled receiver holds the output register and
// the sequencer waits on it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module edf_multicore_task_scheduler #(
   parameter int TASK_SLOTS = 64,
   parameter int MAX_CORES  = 8,
   parameter int TIME_BITS  = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [15:0]          req_task_id,
   input  logic [15:0]          req_exec_time,
   input  logic [TIME_BITS-1:0] req_release_time,
   input  logic [TIME_BITS-1:0] req_deadline,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_kind,
   output logic [15:0]          rsp_assigned_task,
   output logic [3:0]           rsp_core_number,
   output logic [TIME_BITS-1:0] rsp_start_time,
   output logic                 rsp_all_done,
   output logic                 rsp_last,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int NB = $clog2(MAX_CORES + 1);
   localparam int RW = $clog2(edfs_pkg::MAX_RESULTS);
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   edfs_pkg::state_type state_ff, state_in;
   logic [3:0]            ccount_ff, ccount_in;
   logic [TIME_BITS:0]    free_at_ff [MAX_CORES];
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic                  stop_ff, stop_in;
   logic                  cmd_ff;
   logic [15:0]           id_ff, run_ff;
   logic [TIME_BITS-1:0]  rel_ff, due_ff;
   logic [CW:0]           cidx_ff, cidx_in;
   logic [NB-1:0]         cores_lim;
   logic [3:0]            nres_ff, nres_in;
   logic [3:0]            eidx_ff, eidx_in;
   logic                  out_last;
   logic [2:0]            rkind_ff [edfs_pkg::MAX_RESULTS];
   logic [15:0]           rtask_ff [edfs_pkg::MAX_RESULTS];
   logic [3:0]            rcore_ff [edfs_pkg::MAX_RESULTS];
   logic                  bwr;
   logic [RW-1:0]         bidx;
   logic [2:0]            bkind;
   logic [15:0]           btask;
   logic [3:0]            bcore;
   logic                  ovalid_ff, ovalid_in;
   logic [2:0]            okind_ff, okind_in;
   logic [15:0]           otask_ff, otask_in;
   logic [3:0]            ocore_ff, ocore_in;
   logic [TIME_BITS-1:0]  ostart_ff, ostart_in;
   logic                  olast_ff, olast_in;
   logic                  odone_ff, odone_in;
   logic [TIME_BITS:0]    finish;
   logic                  core_wr;
   logic                  wr_en, clr_en, rel_scan, core_free;
   edfs_pkg::scan_ctl_type scan_ctl;
   logic                  scan_busy, found, free_found, any_left;
   logic [SW-1:0]         found_slot, free_slot;
   logic [15:0]           best_ident, best_run;
   logic [TIME_BITS-1:0]  best_due;
   logic                  csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == edfs_pkg::REG_CORE_COUNT;
   assign csr_prdata = (csr_paddr[2] == edfs_pkg::REG_CORE_COUNT) ? {28'd0, ccount_ff} : '0;
   assign ccount_in = csr_wr ? csr_pwdata[3:0] : ccount_ff;

   always_comb begin
      if (ccount_ff == 4'd0) begin
         cores_lim = NB'(1);
      end else if (32'(ccount_ff) > MAX_CORES) begin
         cores_lim = NB'(MAX_CORES);
      end else begin
         cores_lim = NB'(ccount_ff);
      end
   end

   assign core_free = free_at_ff[cidx_ff[CW-1:0]] <= {1'b0, now_ff};
   assign finish    = {1'b0, now_ff} + (TIME_BITS+1)'(best_run);
   assign out_last  = (eidx_ff + 4'd1) == nres_ff;

   edfs_slot_store #(.TASK_SLOTS(TASK_SLOTS), .TIME_BITS(TIME_BITS)) u_store (
      .clock, .reset,
      .wr_en, .wr_slot(free_slot), .wr_ident(id_ff), .wr_run(run_ff),
      .wr_release(rel_ff), .wr_due(due_ff),
      .clr_en, .clr_slot(found_slot),
      .scan_ctl, .rel_scan, .now(now_ff),
      .scan_busy, .found, .found_slot, .free_found, .free_slot, .any_left,
      .best_ident, .best_run, .best_due
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edfs_pkg::S_IDLE;
         ccount_ff    <= 4'd1;
         now_ff       <= '0;
         stop_ff      <= 1'b0;
         cidx_ff      <= '0;
         nres_ff      <= '0;
         eidx_ff      <= '0;
         ovalid_ff    <= 1'b0;
         for (int i = 0; i < MAX_CORES; i++) begin
            free_at_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ccount_ff    <= ccount_in;
         now_ff       <= now_in;
         stop_ff      <= stop_in;
         cidx_ff      <= cidx_in;
         nres_ff      <= nres_in;
         eidx_ff      <= eidx_in;
         ovalid_ff    <= ovalid_in;
         if (core_wr) begin
            free_at_ff[cidx_ff[CW-1:0]] <= finish;
         end
      end
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
         id_ff  <= req_task_id;
         run_ff <= req_exec_time;
         rel_ff <= req_release_time;
         due_ff <= req_deadline;
      end
      // beats of one command wait here until the command is complete
      if (bwr) begin
         rkind_ff[bidx] <= bkind;
         rtask_ff[bidx] <= btask;
         rcore_ff[bidx] <= bcore;
      end
      okind_ff  <= okind_in;
      otask_ff  <= otask_in;
      ocore_ff  <= ocore_in;
      ostart_ff <= ostart_in;
      olast_ff  <= olast_in;
      odone_ff  <= odone_in;
   end

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      stop_in      = stop_ff;
      cidx_in      = cidx_ff;
      nres_in      = nres_ff;
      eidx_in      = eidx_ff;
      ovalid_in    = ovalid_ff;
      okind_in     = okind_ff;
      otask_in     = otask_ff;
      ocore_in     = ocore_ff;
      ostart_in    = ostart_ff;
      olast_in     = olast_ff;
      odone_in     = odone_ff;
      bwr          = 1'b0;
      bidx         = nres_ff[RW-1:0];
      bkind        = edfs_pkg::KIND_IDLE;
      btask        = '0;
      bcore        = '0;
      wr_en        = 1'b0;
      clr_en       = 1'b0;
      core_wr      = 1'b0;
      rel_scan     = 1'b0;
      scan_ctl     = '0;
      req_ready    = 1'b0;
      if (ovalid_ff && rsp_ready) begin
         ovalid_in = 1'b0;
      end
      unique case (state_ff)
         edfs_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               nres_in = '0;
               bidx    = '0;
               if (req_cmd) begin
                  if (stop_ff) begin
                     bwr = 1'b1;
                     bkind = edfs_pkg::KIND_STOPPED;
                     nres_in = 4'd1;
                     scan_ctl.start = 1'b1;
                     state_in = edfs_pkg::S_DONE_SCAN;
                  end else begin
                     rel_scan = 1'b1;
                     state_in = edfs_pkg::S_REL_SCAN;
                  end
               end else begin
                  btask = req_task_id;
                  if (stop_ff) begin
                     bwr = 1'b1;
                     bkind = edfs_pkg::KIND_REJECTED;
                     nres_in = 4'd1;
                     scan_ctl.start = 1'b1;
                     state_in = edfs_pkg::S_DONE_SCAN;
                  end else if (req_exec_time == '0 || req_deadline == '0) begin
                     bwr = 1'b1;
                     bkind = edfs_pkg::KIND_INVALID;
                     nres_in = 4'd1;
                     scan_ctl.start = 1'b1;
                     state_in = edfs_pkg::S_DONE_SCAN;
                  end else begin
                     scan_ctl.start = 1'b1;
                     state_in = edfs_pkg::S_SUB_SCAN;
                  end
               end
            end
         end
         edfs_pkg::S_SUB_SCAN: begin
            state_in = edfs_pkg::S_SUB_WAIT;
         end
         edfs_pkg::S_SUB_WAIT: begin
            if (!scan_busy) begin
               bwr   = 1'b1;
               bidx  = '0;
               btask = id_ff;
               if (free_found) begin
                  wr_en = 1'b1;
                  bkind = edfs_pkg::KIND_ACCEPTED;
               end else begin
                  bkind = edfs_pkg::KIND_FULL;
               end
               nres_in = 4'd1;
               scan_ctl.start = 1'b1;
               state_in = edfs_pkg::S_DONE_SCAN;
            end
         end
         edfs_pkg::S_REL_SCAN: begin
            if (!scan_busy) begin
               cidx_in  = '0;
               state_in = edfs_pkg::S_CORE;
            end
         end
         edfs_pkg::S_CORE: begin
            // walk cores one per cycle to find the lowest free one
            if (nres_ff == 4'(edfs_pkg::MAX_RESULTS) || cidx_ff >= (CW+1)'(cores_lim)) begin
               state_in = edfs_pkg::S_EMIT;
            end else if (core_free) begin
               scan_ctl.start = 1'b1;
               scan_ctl.mode_best = 1'b1;
               state_in = edfs_pkg::S_BEST_SCAN;
            end else begin
               cidx_in = cidx_ff + 1'b1;
            end
         end
         edfs_pkg::S_BEST_SCAN: begin
            state_in = edfs_pkg::S_BEST_WAIT;
         end
         edfs_pkg::S_BEST_WAIT: begin
            if (!scan_busy) begin
               state_in = found ? edfs_pkg::S_ASSIGN : edfs_pkg::S_EMIT;
            end
         end
         edfs_pkg::S_ASSIGN: begin
            clr_en  = 1'b1;
            bwr     = 1'b1;
            btask   = best_ident;
            bcore   = 4'(cidx_ff) + 4'd1;
            nres_in = nres_ff + 1'b1;
            if ({1'b0, best_due} < finish) begin
               bkind    = edfs_pkg::KIND_MISSED;
               stop_in  = 1'b1;
               state_in = edfs_pkg::S_EMIT;
            end else begin
               bkind    = edfs_pkg::KIND_ASSIGNED;
               core_wr  = 1'b1;
               state_in = edfs_pkg::S_CORE;
            end
         end
         edfs_pkg::S_EMIT: begin
            if (nres_ff == '0) begin
               bwr     = 1'b1;
               bkind   = edfs_pkg::KIND_IDLE;
               nres_in = 4'd1;
            end
            scan_ctl.start = 1'b1;
            state_in = edfs_pkg::S_DONE_SCAN;
         end
         edfs_pkg::S_DONE_SCAN: begin
            eidx_in  = '0;
            state_in = edfs_pkg::S_OUT;
         end
         edfs_pkg::S_OUT: begin
            if (!scan_busy && !ovalid_ff) begin
               ovalid_in = 1'b1;
               okind_in  = rkind_ff[eidx_ff[RW-1:0]];
               otask_in  = rtask_ff[eidx_ff[RW-1:0]];
               ocore_in  = rcore_ff[eidx_ff[RW-1:0]];
               ostart_in = now_ff;
               odone_in  = !any_left;
               olast_in  = out_last;
               eidx_in   = eidx_ff + 4'd1;
               if (out_last) begin
                  // a tick while stopped leaves time frozen
                  if (cmd_ff && rkind_ff[0] != edfs_pkg::KIND_STOPPED && now_ff != TIME_MAX) begin
                     now_in = now_ff + 1'b1;
                  end
                  state_in = edfs_pkg::S_IDLE;
               end
            end
         end
         default: state_in = edfs_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_kind          = okind_ff;
   assign rsp_assigned_task = otask_ff;
   assign rsp_core_number   = ocore_ff;
   assign rsp_start_time    = ostart_ff;
   assign rsp_all_done      = odone_ff;
   assign rsp_last          = olast_ff;

   `ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == edfs_pkg::S_IDLE)
   `ASSERT_IMP(a_core_nonzero, clock, reset,
      rsp_valid && (rsp_kind == edfs_pkg::KIND_ASSIGNED || rsp_kind == edfs_pkg::KIND_MISSED),
      rsp_core_number != 4'd0)
   `ASSERT_NEXT(a_missed_stops, clock, reset,
      rsp_valid && rsp_kind == edfs_pkg::KIND_MISSED, stop_ff)
endmodule

@@ rtl/edfs_slot_store.sv @@
// slot store memories and the sequential scan unit over them
`timescale 1ns / 1ps
module edfs_slot_store #(
   parameter int TASK_SLOTS = 64,
   parameter int TIME_BITS  = 24,
   localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   // write port
   input  logic                   wr_en,
   input  logic [SW-1:0]          wr_slot,
   input  logic [15:0]            wr_ident,
   input  logic [15:0]            wr_run,
   input  logic [TIME_BITS-1:0]   wr_release,
   input  logic [TIME_BITS-1:0]   wr_due,
   // status write (for clearing a taken task)
   input  logic                   clr_en,
   input  logic [SW-1:0]          clr_slot,
   // scan control
   input  edfs_pkg::scan_ctl_type scan_ctl,
   input  logic                   rel_scan,
   input  logic [TIME_BITS-1:0]   now,
   output logic                   scan_busy,
   output logic                   found,
   output logic [SW-1:0]          found_slot,
   output logic                   free_found,
   output logic [SW-1:0]          free_slot,
   output logic                   any_left,
   output logic [15:0]            best_ident,
   output logic [15:0]            best_run,
   output logic [TIME_BITS-1:0]   best_due
);
   logic [1:0]           status_ff [TASK_SLOTS];
   logic [15:0]          ident_mem [TASK_SLOTS];
   logic [15:0]          run_mem   [TASK_SLOTS];
   logic [TIME_BITS-1:0] rel_mem   [TASK_SLOTS];
   logic [TIME_BITS-1:0] due_mem   [TASK_SLOTS];

   logic [SW:0]          idx_ff, idx_in;
   logic                 busy_ff, busy_in;
   logic                 mode_ff, mode_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [SW-1:0]        rd_slot_ff;
   logic [1:0]           rd_status_ff;
   logic [15:0]          rd_ident_ff, rd_run_ff;
   logic [TIME_BITS-1:0] rd_rel_ff, rd_due_ff;
   logic                 found_ff, found_in;
   logic [SW-1:0]        fslot_ff, fslot_in;
   logic                 free_ff, free_in;
   logic [SW-1:0]        freeslot_ff, freeslot_in;
   logic                 left_ff, left_in;
   logic [15:0]          bid_ff, bid_in, brun_ff, brun_in;
   logic [TIME_BITS-1:0] bdue_ff, bdue_in;
   logic                 better;
   logic                 rel_ff, rel_in;

   // memories: one write, one read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ident_mem[wr_slot] <= wr_ident;
         run_mem[wr_slot]   <= wr_run;
         rel_mem[wr_slot]   <= wr_release;
         due_mem[wr_slot]   <= wr_due;
      end
      rd_slot_ff   <= idx_ff[SW-1:0];
      rd_status_ff <= status_ff[idx_ff[SW-1:0]];
      rd_ident_ff  <= ident_mem[idx_ff[SW-1:0]];
      rd_run_ff    <= run_mem[idx_ff[SW-1:0]];
      rd_rel_ff    <= rel_mem[idx_ff[SW-1:0]];
      rd_due_ff    <= due_mem[idx_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            status_ff[i] <= edfs_pkg::ST_EMPTY;
         end
      end else begin
         if (wr_en) begin
            status_ff[wr_slot] <= edfs_pkg::ST_PENDING;
         end
         if (clr_en) begin
            status_ff[clr_slot] <= edfs_pkg::ST_EMPTY;
         end
         // release: promote the slot read last cycle
         if (rel_ff && rd_valid_ff && rd_status_ff == edfs_pkg::ST_PENDING &&
             rd_rel_ff <= now) begin
            status_ff[rd_slot_ff] <= edfs_pkg::ST_READY;
         end
      end
   end

   always_comb begin
      better = (rd_status_ff == edfs_pkg::ST_READY) &&
               (!found_ff || rd_due_ff < bdue_ff ||
                (rd_due_ff == bdue_ff && rd_ident_ff < bid_ff));
      idx_in      = idx_ff;
      busy_in     = busy_ff;
      mode_in     = mode_ff;
      rel_in      = rel_ff;
      rd_valid_in = 1'b0;
      found_in    = found_ff;
      fslot_in    = fslot_ff;
      free_in     = free_ff;
      freeslot_in = freeslot_ff;
      left_in     = left_ff;
      bid_in      = bid_ff;
      brun_in     = brun_ff;
      bdue_in     = bdue_ff;
      if (scan_ctl.start || rel_scan) begin
         idx_in   = '0;
         busy_in  = 1'b1;
         mode_in  = scan_ctl.mode_best;
         rel_in   = rel_scan;
         found_in = 1'b0;
         free_in  = 1'b0;
         left_in  = 1'b0;
      end else if (busy_ff) begin
         if (idx_ff < (SW+1)'(TASK_SLOTS)) begin
            rd_valid_in = 1'b1;
            idx_in = idx_ff + 1'b1;
         end else if (!rd_valid_ff) begin
            busy_in = 1'b0;
         end
      end
      if (rd_valid_ff && !rel_ff) begin
         if (rd_status_ff == edfs_pkg::ST_PENDING || rd_status_ff == edfs_pkg::ST_READY) begin
            left_in = 1'b1;
         end else if (!free_ff) begin
            free_in     = 1'b1;
            freeslot_in = rd_slot_ff;
         end
         if (mode_ff && better) begin
            found_in = 1'b1;
            fslot_in = rd_slot_ff;
            bid_in   = rd_ident_ff;
            brun_in  = rd_run_ff;
            bdue_in  = rd_due_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
         idx_ff      <= '0;
         mode_ff     <= 1'b0;
         rel_ff      <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
         left_ff     <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         rd_valid_ff <= rd_valid_in;
         idx_ff      <= idx_in;
         mode_ff     <= mode_in;
         rel_ff      <= rel_in;
         found_ff    <= found_in;
         free_ff     <= free_in;
         left_ff     <= left_in;
      end
      fslot_ff    <= fslot_in;
      freeslot_ff <= freeslot_in;
      bid_ff      <= bid_in;
      brun_ff     <= brun_in;
      bdue_ff     <= bdue_in;
   end

   assign scan_busy  = busy_ff;
   assign found      = found_ff;
   assign found_slot = fslot_ff;
   assign free_found = free_ff;
   assign free_slot  = freeslot_ff;
   assign any_left   = left_ff;
   assign best_ident = bid_ff;
   assign best_run   = brun_ff;
   assign best_due   = bdue_ff;
endmodule
